// ----- hdl/pop3c_pkg.sv -----
// Shared types, constants and the keyword table of the command line classifier.
package pop3c_pkg;

  localparam logic [7:0] LO_CHAR = 8'h30;
  localparam logic [7:0] HI_CHAR = 8'h7A;
  localparam logic [7:0] UPPER_A = 8'h41;
  localparam logic [7:0] UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [1:0] CLASS_LIST = 2'd0;
  localparam logic [1:0] CLASS_SINGLE = 2'd1;
  localparam logic [1:0] CLASS_RETR = 2'd2;
  localparam logic [1:0] CLASS_UNKNOWN = 2'd3;

  localparam int unsigned MATCH_LEN = 4;
  localparam logic [2:0] LEN_NONE = 3'd7;
  localparam int unsigned NUM_KEYWORDS = 10;

  typedef enum logic [1:0] {
    PHASE_SKIP = 2'd0,
    PHASE_WORD = 2'd1,
    PHASE_DONE = 2'd2
  } word_phase_e;

  typedef struct packed {
    logic [2:0]           len;
    logic [0:3][7:0]      text;
    logic [1:0]           cls;
  } keyword_t;

  typedef struct packed {
    logic                 eol;
    logic [2:0]           len;
    logic [0:3][7:0]      head;
  } word_status_t;

  localparam keyword_t KEYWORDS [NUM_KEYWORDS] = '{
    '{3'd4, "list", CLASS_LIST},
    '{3'd4, "uidl", CLASS_LIST},
    '{3'd3, {"top", 8'h00}, CLASS_LIST},
    '{3'd4, "user", CLASS_SINGLE},
    '{3'd4, "pass", CLASS_SINGLE},
    '{3'd4, "stat", CLASS_SINGLE},
    '{3'd4, "dele", CLASS_SINGLE},
    '{3'd4, "rset", CLASS_SINGLE},
    '{3'd4, "quit", CLASS_SINGLE},
    '{3'd4, "retr", CLASS_RETR}
  };

endpackage

// ----- hdl/pop3c_if.sv -----
// Valid/ready channel interfaces for the byte input and the class result.
interface pop3c_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface pop3c_class_if;
  logic       valid;
  logic       ready;
  logic [1:0] command_class;

  modport source (output valid, output command_class, input ready);
  modport sink (input valid, input command_class, output ready);
endinterface

// ----- hdl/pop3c_line_tracker.sv -----
// Line state: CR tracking, word phase, and capture of the folded first word.
module pop3c_line_tracker #(
  parameter int unsigned KEY_LEN = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [7:0]                  byte_i,
  output pop3c_pkg::word_status_t     status_o
);

  localparam int unsigned CW = $clog2(KEY_LEN + 2);
  localparam int unsigned IW = $clog2(KEY_LEN);

  logic                     cr_q, cr_d;
  pop3c_pkg::word_phase_e   phase_q, phase_d;
  logic [CW-1:0]            count_q, count_d;
  logic [7:0]               chars_q [KEY_LEN];
  logic                     char_we;
  logic [7:0]               char_wd;
  logic                     in_range;
  logic                     capture;
  logic                     eol;

  assign in_range = (byte_i >= pop3c_pkg::LO_CHAR) && (byte_i <= pop3c_pkg::HI_CHAR);
  assign eol = cr_q && (byte_i == pop3c_pkg::CHAR_LF);

  always_comb begin
    cr_d    = cr_q;
    phase_d = phase_q;
    count_d = count_q;
    capture = 1'b0;
    char_we = 1'b0;
    char_wd = byte_i;
    if ((byte_i >= pop3c_pkg::UPPER_A) && (byte_i <= pop3c_pkg::UPPER_Z)) begin
      char_wd = byte_i + pop3c_pkg::CASE_OFFSET;
    end
    if (step_i) begin
      if (eol) begin
        cr_d    = 1'b0;
        phase_d = pop3c_pkg::PHASE_SKIP;
        count_d = '0;
      end else begin
        cr_d = (byte_i == pop3c_pkg::CHAR_CR);
        case (phase_q)
          pop3c_pkg::PHASE_SKIP: begin
            if (in_range) begin
              phase_d = pop3c_pkg::PHASE_WORD;
              capture = 1'b1;
            end
          end
          pop3c_pkg::PHASE_WORD: begin
            if (in_range) begin
              capture = 1'b1;
            end else begin
              phase_d = pop3c_pkg::PHASE_DONE;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
        if (capture) begin
          if (count_q < CW'(KEY_LEN)) begin
            char_we = 1'b1;
            count_d = count_q + CW'(1);
          end else begin
            count_d = CW'(KEY_LEN + 1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_q    <= 1'b0;
      phase_q <= pop3c_pkg::PHASE_SKIP;
      count_q <= '0;
    end else begin
      cr_q    <= cr_d;
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_we) begin
      chars_q[count_q[IW-1:0]] <= char_wd;
    end
  end

  always_comb begin
    status_o.eol = eol;
    status_o.len = (count_q > CW'(pop3c_pkg::MATCH_LEN)) ? pop3c_pkg::LEN_NONE
                                                         : count_q[2:0];
    for (int i = 0; i < 4; i++) begin
      status_o.head[i] = chars_q[i];
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(KEY_LEN + 1))
    else $error("word length counter out of range");

  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && eol |=> (count_q == '0) && (phase_q == pop3c_pkg::PHASE_SKIP) && !cr_q)
    else $error("line state not cleared after CR LF");
`endif

endmodule

// ----- hdl/pop3c_keyword_match.sv -----
// Compare the captured word against the keyword table and give its class.
module pop3c_keyword_match (
  input  pop3c_pkg::word_status_t word_i,
  output logic [1:0]              class_o
);

  logic [pop3c_pkg::NUM_KEYWORDS-1:0] hit;

  always_comb begin
    for (int k = 0; k < pop3c_pkg::NUM_KEYWORDS; k++) begin
      hit[k] = (word_i.len == pop3c_pkg::KEYWORDS[k].len);
      for (int i = 0; i < 4; i++) begin
        if ((3'(i) < word_i.len) &&
            (word_i.head[i] != pop3c_pkg::KEYWORDS[k].text[i])) begin
          hit[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    class_o = pop3c_pkg::CLASS_UNKNOWN;
    for (int k = pop3c_pkg::NUM_KEYWORDS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        class_o = pop3c_pkg::KEYWORDS[k].cls;
      end
    end
  end

endmodule

// ----- hdl/pop3_command_line_classifier.sv -----
// Top level of the command line classifier: input register, line state, result register.
//
// Client bytes enter on byte_i, one transaction per byte. The block skips
// leading bytes outside '0'..'z', captures the first word of the line with
// A-Z folded to lower case, and on LF directly after CR sends one
// transaction on class_o with the word's class (0 list/uidl/top, 1 user,
// pass, stat, dele, rset, quit, 2 retr, 3 anything else). Other bytes give
// no result. Words longer than KEY_LEN characters are classed unknown.
// Throughput: one byte per cycle, unless a line end waits on a stalled
// class_o, set by the update of the line state behind the input register.
// An LF's class is loaded from the input register into the result register.
// Reset clears the line state and both valid flags; the captured word
// storage is not reset. When class_o stalls, the result register holds;
// bytes that give no result keep flowing, and a byte ending a line waits
// in the input register until the result register frees, which drops
// byte_i.ready.
module pop3_command_line_classifier #(
  parameter int unsigned KEY_LEN = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pop3c_byte_if.sink   byte_i,
  pop3c_class_if.source class_o
);

  logic                     s1_valid_q, s1_valid_d;
  logic [7:0]               s1_byte_q;
  logic                     s1_fire;
  logic                     out_valid_q, out_valid_d;
  logic [1:0]               out_class_q;
  logic                     out_load;
  logic [1:0]               word_class;
  pop3c_pkg::word_status_t  status;

  pop3c_line_tracker #(
    .KEY_LEN (KEY_LEN)
  ) u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_fire),
    .byte_i   (s1_byte_q),
    .status_o (status)
  );

  pop3c_keyword_match u_match (
    .word_i  (status),
    .class_o (word_class)
  );

  assign s1_fire  = s1_valid_q && (!status.eol || !out_valid_q || class_o.ready);
  assign out_load = s1_fire && status.eol;
  assign byte_i.ready = !s1_valid_q || s1_fire;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (byte_i.valid && byte_i.ready) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (class_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      s1_byte_q <= byte_i.byte_in;
    end
    if (out_load) begin
      out_class_q <= word_class;
    end
  end

  assign class_o.valid         = out_valid_q;
  assign class_o.command_class = out_class_q;

`ifndef SYNTHESIS
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && (class_o.command_class == $past(word_class)))
    else $error("class not presented after end of line");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_fire |=> s1_valid_q && $stable(s1_byte_q))
    else $error("stalled input byte lost");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_valid_q || class_o.ready)
    else $error("pending class overwritten");
`endif

endmodule

// ----- tb/pop3_command_line_classifier_test.sv -----
// Self-checking POP3 command line classifier testbench: directed rows, a stall, random lines.
`timescale 1ns / 100ps

module pop3_command_line_classifier_test;

  localparam int unsigned WORD_MAX = 4;
  localparam int unsigned BYTE_TARGET = 1000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned NUM_ROWS = 26;
  localparam int unsigned NUM_WORDS = 10;

  typedef struct {
    logic [7:0] data;
    bit         fixed;
    logic [1:0] cls;
  } byte_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pop3c_byte_if  byte_if ();
  pop3c_class_if class_if ();

  pop3_command_line_classifier #(
    .KEY_LEN(WORD_MAX)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .byte_i (byte_if),
    .class_o(class_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  string cmd_words [NUM_WORDS] = '{
    "list", "uidl", "top", "user", "pass", "stat", "dele", "rset", "quit", "retr"
  };
  logic [1:0] cmd_class [NUM_WORDS] = '{
    pop3c_pkg::CLASS_LIST, pop3c_pkg::CLASS_LIST, pop3c_pkg::CLASS_LIST,
    pop3c_pkg::CLASS_SINGLE, pop3c_pkg::CLASS_SINGLE, pop3c_pkg::CLASS_SINGLE,
    pop3c_pkg::CLASS_SINGLE, pop3c_pkg::CLASS_SINGLE, pop3c_pkg::CLASS_SINGLE,
    pop3c_pkg::CLASS_RETR
  };

  byte_row_t directed_rows [NUM_ROWS] = '{
    '{pop3c_pkg::CHAR_CR, 1'b0, pop3c_pkg::CLASS_LIST},
    '{pop3c_pkg::CHAR_LF, 1'b1, pop3c_pkg::CLASS_UNKNOWN},
    '{"R", 1'b0, pop3c_pkg::CLASS_LIST},
    '{"e", 1'b0, pop3c_pkg::CLASS_LIST},
    '{"T", 1'b0, pop3c_pkg::CLASS_LIST},
    '{"r", 1'b0, pop3c_pkg::CLASS_LIST},
    '{pop3c_pkg::CHAR_CR, 1'b0, pop3c_pkg::CLASS_LIST},
    '{pop3c_pkg::CHAR_LF, 1'b0, pop3c_pkg::CLASS_LIST},
    '{8'h00, 1'b0, pop3c_pkg::CLASS_LIST},
    '{8'hFF, 1'b0, pop3c_pkg::CLASS_LIST},
    '{8'h2F, 1'b0, pop3c_pkg::CLASS_LIST},
    '{8'h7B, 1'b0, pop3c_pkg::CLASS_LIST},
    '{"T", 1'b0, pop3c_pkg::CLASS_LIST},
    '{"O", 1'b0, pop3c_pkg::CLASS_LIST},
    '{"P", 1'b0, pop3c_pkg::CLASS_LIST},
    '{pop3c_pkg::CHAR_LF, 1'b0, pop3c_pkg::CLASS_LIST},
    '{"x", 1'b0, pop3c_pkg::CLASS_LIST},
    '{pop3c_pkg::CHAR_CR, 1'b0, pop3c_pkg::CLASS_LIST},
    '{pop3c_pkg::CHAR_LF, 1'b0, pop3c_pkg::CLASS_LIST},
    '{"z", 1'b0, pop3c_pkg::CLASS_LIST},
    '{"0", 1'b0, pop3c_pkg::CLASS_LIST},
    '{"z", 1'b0, pop3c_pkg::CLASS_LIST},
    '{"0", 1'b0, pop3c_pkg::CLASS_LIST},
    '{"z", 1'b0, pop3c_pkg::CLASS_LIST},
    '{pop3c_pkg::CHAR_CR, 1'b0, pop3c_pkg::CLASS_LIST},
    '{pop3c_pkg::CHAR_LF, 1'b1, pop3c_pkg::CLASS_UNKNOWN}
  };

  // line tracker state
  bit                     line_cr;
  pop3c_pkg::word_phase_e line_phase;
  logic [7:0]             line_chars [WORD_MAX];
  int unsigned            line_count;

  logic [1:0] class_expected_q [$];
  logic [1:0] predicted_class;
  logic [1:0] cur_cls;
  bit         cur_fixed;
  bit         sender_burst;
  bit         hold_req;
  bit         drained;
  int unsigned error_count;
  int unsigned bytes_sent;
  int unsigned lines_sent;
  int unsigned classes_checked;
  int unsigned class_seen [4];
  int unsigned idle_cycles;

  function automatic void clear_line();
    line_cr = 1'b0;
    line_phase = pop3c_pkg::PHASE_SKIP;
    line_count = 0;
    foreach (line_chars[i]) line_chars[i] = 8'h00;
  endfunction

  function automatic logic [1:0] word_class();
    bit same;
    if (line_count == 0 || line_count > WORD_MAX) return pop3c_pkg::CLASS_UNKNOWN;
    for (int k = 0; k < NUM_WORDS; k++) begin
      if (cmd_words[k].len() != line_count) continue;
      same = 1'b1;
      for (int i = 0; i < line_count; i++) begin
        if (line_chars[i] != cmd_words[k][i]) same = 1'b0;
      end
      if (same) return cmd_class[k];
    end
    return pop3c_pkg::CLASS_UNKNOWN;
  endfunction

  function automatic bit track_byte(input logic [7:0] b, output logic [1:0] cls);
    bit         in_range;
    logic [7:0] c;
    in_range = (b >= pop3c_pkg::LO_CHAR) && (b <= pop3c_pkg::HI_CHAR);
    cls = pop3c_pkg::CLASS_UNKNOWN;
    if (line_cr && b == pop3c_pkg::CHAR_LF) begin
      cls = word_class();
      clear_line();
      return 1'b1;
    end
    line_cr = (b == pop3c_pkg::CHAR_CR);
    if (line_phase == pop3c_pkg::PHASE_SKIP && in_range) line_phase = pop3c_pkg::PHASE_WORD;
    if (line_phase == pop3c_pkg::PHASE_WORD) begin
      if (in_range) begin
        c = b;
        if (c >= pop3c_pkg::UPPER_A && c <= pop3c_pkg::UPPER_Z) begin
          c = c + pop3c_pkg::CASE_OFFSET;
        end
        if (line_count < WORD_MAX) begin
          line_chars[line_count] = c;
          line_count++;
        end else begin
          line_count = WORD_MAX + 1;
        end
      end else begin
        line_phase = pop3c_pkg::PHASE_DONE;
      end
    end
    return 1'b0;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] outside_byte();
    if ($urandom_range(0, 1)) return 8'($urandom_range(8'h00, 8'h2F));
    return 8'($urandom_range(8'h7B, 8'hFF));
  endfunction

  function automatic logic [7:0] inside_byte();
    return 8'($urandom_range(pop3c_pkg::LO_CHAR, pop3c_pkg::HI_CHAR));
  endfunction

  always @(posedge clk) begin
    if (rst_n && byte_if.valid && byte_if.ready) begin
      if (track_byte(byte_if.byte_in, predicted_class)) begin
        class_expected_q.push_back(cur_fixed ? cur_cls : predicted_class);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && class_if.valid && class_if.ready) begin
      if (class_expected_q.size() == 0) begin
        $display("%0t: unexpected class transaction, expected none, actual %0d",
                 $time, class_if.command_class);
        error_count++;
      end else begin
        if (class_if.command_class !== class_expected_q[0]) begin
          $display("%0t: class mismatch, expected %0d, actual %0d",
                   $time, class_expected_q[0], class_if.command_class);
          error_count++;
        end
        class_seen[class_expected_q[0]]++;
        classes_checked++;
        void'(class_expected_q.pop_front());
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((byte_if.valid && byte_if.ready) || (class_if.valid && class_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: watchdog expired, %0d classes still pending",
             $time, class_expected_q.size());
    $display("pop3_command_line_classifier_test NOT OK");
    $finish;
  end

  // receiver: random ready runs, plus a long hold-off on request
  initial begin
    int unsigned on_left;
    int unsigned off_left;
    on_left = 0;
    off_left = 0;
    class_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        class_if.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (on_left > 0) begin
        class_if.ready = 1'b1;
        on_left--;
      end else if (off_left > 0) begin
        class_if.ready = 1'b0;
        off_left--;
      end else begin
        on_left = $urandom_range(0, 19);
        off_left = pick_gap();
        class_if.ready = 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit fixed, input logic [1:0] cls);
    int unsigned gap;
    byte_if.valid = 1'b1;
    byte_if.byte_in = b;
    cur_fixed = fixed;
    cur_cls = cls;
    do @(posedge clk); while (!byte_if.ready);
    bytes_sent++;
    @(negedge clk);
    gap = sender_burst ? 0 : pick_gap();
    if (gap > 0) begin
      byte_if.valid = 1'b0;
      byte_if.byte_in = 8'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_line(input string word);
    for (int i = 0; i < word.len(); i++) send_byte(word[i], 1'b0, pop3c_pkg::CLASS_UNKNOWN);
    send_byte(pop3c_pkg::CHAR_CR, 1'b0, pop3c_pkg::CLASS_UNKNOWN);
    send_byte(pop3c_pkg::CHAR_LF, 1'b0, pop3c_pkg::CLASS_UNKNOWN);
    lines_sent++;
  endtask

  task automatic send_random_line();
    int unsigned r;
    int unsigned n;
    logic [7:0]  c;
    string       w;
    r = $urandom_range(0, 99);
    sender_burst = ($urandom_range(0, 4) == 0);
    if (r < 10) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        r = $urandom_range(0, 99);
        c = (r < 15) ? pop3c_pkg::CHAR_CR :
            (r < 30) ? pop3c_pkg::CHAR_LF : 8'($urandom_range(0, 255));
        send_byte(c, 1'b0, pop3c_pkg::CLASS_UNKNOWN);
      end
      return;
    end
    repeat ($urandom_range(0, 2)) send_byte(outside_byte(), 1'b0, pop3c_pkg::CLASS_UNKNOWN);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      w = cmd_words[$urandom_range(0, NUM_WORDS - 1)];
      for (int i = 0; i < w.len(); i++) begin
        c = w[i];
        if ($urandom_range(0, 1)) c = c - pop3c_pkg::CASE_OFFSET;
        send_byte(c, 1'b0, pop3c_pkg::CLASS_UNKNOWN);
      end
    end else if (r < 90) begin
      repeat ($urandom_range(1, 6)) send_byte(inside_byte(), 1'b0, pop3c_pkg::CLASS_UNKNOWN);
    end
    if ($urandom_range(0, 1)) begin
      send_byte(outside_byte(), 1'b0, pop3c_pkg::CLASS_UNKNOWN);
      repeat ($urandom_range(0, 6)) begin
        c = $urandom_range(0, 1) ? inside_byte() : 8'($urandom_range(0, 255));
        send_byte(c, 1'b0, pop3c_pkg::CLASS_UNKNOWN);
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      send_byte(pop3c_pkg::CHAR_CR, 1'b0, pop3c_pkg::CLASS_UNKNOWN);
    end
    send_byte(pop3c_pkg::CHAR_CR, 1'b0, pop3c_pkg::CLASS_UNKNOWN);
    send_byte(pop3c_pkg::CHAR_LF, 1'b0, pop3c_pkg::CLASS_UNKNOWN);
    lines_sent++;
  endtask

  initial begin
    byte_if.valid = 1'b0;
    byte_if.byte_in = 8'h00;
    cur_fixed = 1'b0;
    cur_cls = pop3c_pkg::CLASS_UNKNOWN;
    sender_burst = 1'b0;
    hold_req = 1'b0;
    drained = 1'b0;
    error_count = 0;
    bytes_sent = 0;
    lines_sent = 0;
    classes_checked = 0;
    foreach (class_seen[i]) class_seen[i] = 0;
    clear_line();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].fixed, directed_rows[i].cls);

    // stall the result side while short lines keep coming
    hold_req = 1'b1;
    sender_burst = 1'b1;
    repeat (6) send_line("quit");
    send_line("");
    sender_burst = 1'b0;

    while (bytes_sent < BYTE_TARGET) begin
      send_random_line();
      if (!drained && bytes_sent >= BYTE_TARGET / 2) begin
        drained = 1'b1;
        byte_if.valid = 1'b0;
        while (class_expected_q.size() != 0) @(negedge clk);
      end
    end
    send_line("retr");

    byte_if.valid = 1'b0;
    while (class_expected_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Sent %0d bytes in %0d lines; checked %0d classes", bytes_sent, lines_sent,
             classes_checked);
    $display("Classes seen: list %0d, single %0d, retr %0d, unknown %0d",
             class_seen[pop3c_pkg::CLASS_LIST], class_seen[pop3c_pkg::CLASS_SINGLE],
             class_seen[pop3c_pkg::CLASS_RETR], class_seen[pop3c_pkg::CLASS_UNKNOWN]);
    if (error_count == 0) begin
      $display("pop3_command_line_classifier_test OK");
    end else begin
      $display("pop3_command_line_classifier_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/pop3c_pkg.sv
hdl/pop3c_if.sv
hdl/pop3c_line_tracker.sv
hdl/pop3c_keyword_match.sv
hdl/pop3_command_line_classifier.sv
tb/pop3_command_line_classifier_test.sv
